// File: rtl/nsa_pkg.sv
// ----------------------------------------------------------------------------
// nsa_pkg: shared types and helpers for the spill-shift ALU
// Operation codes, status codes, the pipeline stage record and one step of
// the restoring divider.
// ----------------------------------------------------------------------------
package nsa_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned DivSteps = WordBits;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_MOD = 4'd4,
    MODE_AND = 4'd5,
    MODE_OR  = 4'd6,
    MODE_NOT = 4'd7,
    MODE_NEG = 4'd8,
    MODE_CMP = 4'd9,
    MODE_INC = 4'd10,
    MODE_SHL = 4'd11,
    MODE_SHR = 4'd12,
    MODE_ASR = 4'd13
  } mode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CARRY     = 3'd1;
  localparam logic [2:0] ST_BORROW    = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ST_MOD_ZERO  = 3'd4;
  localparam logic [2:0] ST_SHIFT_FAR = 3'd5;
  localparam logic [2:0] ST_ONE_WORD  = 3'd6;
  localparam logic [2:0] ST_TWO_WORD  = 3'd7;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] b;
    logic [31:0] dq;
    logic [31:0] dr;
    logic [31:0] res;
    logic [31:0] hi;
    logic [2:0]  st;
  } stage_t;

  // One restoring division step: brings in the next dividend bit.
  function automatic stage_t div_step(stage_t s);
    logic [32:0] t;
    logic [32:0] d;
    stage_t      o;
    o = s;
    t = {s.dr, s.dq[31]};
    d = t - {1'b0, s.b};
    if (!d[32]) begin
      o.dr = d[31:0];
      o.dq = {s.dq[30:0], 1'b1};
    end else begin
      o.dr = t[31:0];
      o.dq = {s.dq[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: rtl/nsa_front.sv
// ----------------------------------------------------------------------------
// nsa_front: combinational operations
// Computes every mode but divide and modulus, and seeds the divider.
// ----------------------------------------------------------------------------
module nsa_front import nsa_pkg::*; (
  input  mode_t       mode,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [5:0]  n,
  input  logic [31:0] spill,
  input  logic [31:0] fill,
  output stage_t      st_o
);

  logic [32:0] sum;
  logic [32:0] inc;
  logic [63:0] prod;
  logic [63:0] lres;
  logic [63:0] lhi;
  logic [63:0] rres;
  logic [63:0] rhi;
  logic [31:0] rfill;
  logic        far;

  assign sum   = {1'b0, a} + {1'b0, b};
  assign inc   = {1'b0, a} + 33'd1;
  assign prod  = a * b;
  assign far   = n[5];
  assign rfill = (mode == MODE_ASR) ? {32{a[31]}} : fill;
  assign lres  = {a, fill} << n[4:0];
  assign lhi   = {spill, a} << n[4:0];
  assign rres  = {rfill, a} >> n[4:0];
  assign rhi   = {a, spill} >> n[4:0];

  always_comb begin
    st_o      = '0;
    st_o.mode = mode;
    st_o.b    = b;
    st_o.dq   = a;
    st_o.dr   = '0;
    st_o.res  = '0;
    st_o.hi   = '0;
    st_o.st   = ST_OK;
    case (mode)
      MODE_ADD: begin
        st_o.res = sum[31:0];
        st_o.st  = sum[32] ? ST_CARRY : ST_OK;
      end
      MODE_SUB: begin
        st_o.res = a - b;
        st_o.st  = (b > a) ? ST_BORROW : ST_OK;
      end
      MODE_MUL: begin
        st_o.res = prod[31:0];
        st_o.hi  = prod[63:32];
        st_o.st  = (prod[63:32] == '0) ? ST_ONE_WORD : ST_TWO_WORD;
      end
      MODE_AND: st_o.res = a & b;
      MODE_OR:  st_o.res = a | b;
      MODE_NOT: st_o.res = ~a;
      MODE_NEG: st_o.res = ~a + 32'd1;
      MODE_CMP: st_o.res = {30'd0, (a < b) ? CMP_LT : ((a == b) ? CMP_EQ : CMP_GT)};
      MODE_INC: begin
        st_o.res = inc[31:0];
        st_o.st  = inc[32] ? ST_CARRY : ST_OK;
      end
      MODE_SHL: begin
        st_o.res = far ? a : lres[63:32];
        st_o.hi  = far ? spill : lhi[63:32];
        st_o.st  = far ? ST_SHIFT_FAR : ST_OK;
      end
      MODE_SHR, MODE_ASR: begin
        st_o.res = far ? a : rres[31:0];
        st_o.hi  = far ? spill : rhi[31:0];
        st_o.st  = far ? ST_SHIFT_FAR : ST_OK;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/natural32_alu_with_spill_shift.sv
// ----------------------------------------------------------------------------
// natural32_alu_with_spill_shift: pipelined unsigned 32-bit ALU
// Arithmetic, logic, compare, chained spill shifts and a one-bit-per-stage
// divider in a single elastic pipeline.
// ----------------------------------------------------------------------------
// The block accepts one item per clock while in_stall is low and returns one
// result item for each, in order. The pipeline depth is set by the divider: a
// quotient bit is produced in each of 32 stages, and every mode travels the
// same path so that order is kept. Stage zero holds the accepted item, the
// next stage holds the combinational front results (including the full
// product) and the seeded divider, and the last stage drives the outputs
// directly. Each stage advances whenever it is empty or the stage after it
// advances, so bubbles are squeezed out and new items are taken while a
// finished result waits to be read.
module natural32_alu_with_spill_shift import nsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [5:0]  in_shift_count,
  input  logic [31:0] in_spill_in,
  input  logic [31:0] in_fill_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic [31:0] out_high_word,
  output logic [2:0]  out_status
);

  localparam int unsigned Last = DivSteps + 1;

  // Stage zero: the accepted item.
  mode_t       mode_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [5:0]  n_r;
  logic [31:0] spill_r;
  logic [31:0] fill_r;

  // Valid bit per stage; s_r[k] sits at stage k + 1.
  logic   [Last:0]     v_r;
  stage_t              s_r [0:DivSteps];
  stage_t              front;
  logic   [Last:0]     adv;
  stage_t              fin;
  logic                bz;

  nsa_front u_front (
    .mode  (mode_r),
    .a     (a_r),
    .b     (b_r),
    .n     (n_r),
    .spill (spill_r),
    .fill  (fill_r),
    .st_o  (front)
  );

  // A stage moves forward when it is empty or its successor moves.
  always_comb begin
    adv[Last] = !v_r[Last] || !out_stall;
    for (int k = Last - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k + 1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= Last; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      mode_r  <= mode_t'(in_mode);
      a_r     <= in_operand_a;
      b_r     <= in_operand_b;
      n_r     <= in_shift_count;
      spill_r <= in_spill_in;
      fill_r  <= in_fill_in;
    end
    if (adv[1]) begin
      s_r[0] <= front;
    end
    for (int k = 1; k <= DivSteps; k++) begin
      if (adv[k + 1]) begin
        s_r[k] <= div_step(s_r[k - 1]);
      end
    end
  end

  // Divide and modulus take their words from the divider at the end.
  assign fin = s_r[DivSteps];
  assign bz  = (fin.b == '0);

  always_comb begin
    out_result    = fin.res;
    out_high_word = fin.hi;
    out_status    = fin.st;
    case (fin.mode)
      MODE_DIV: begin
        out_result    = bz ? '0 : fin.dq;
        out_high_word = bz ? '0 : fin.dr;
        out_status    = bz ? ST_DIV_ZERO : ST_OK;
      end
      MODE_MOD: begin
        out_result    = bz ? '0 : fin.dr;
        out_high_word = '0;
        out_status    = bz ? ST_MOD_ZERO : ST_OK;
      end
      default: ;
    endcase
  end

  assign out_valid = v_r[Last];

  // The input side can only be held back by a full first stage.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0])
    else $error("input stalled with an empty first stage");

  // A product result always reports its word count.
  a_mul_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fin.mode == MODE_MUL) |->
      (out_status == ST_ONE_WORD || out_status == ST_TWO_WORD))
    else $error("product item without word-count status");

  // Division by zero returns zero words.
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIV_ZERO) |->
      (out_result == '0 && out_high_word == '0))
    else $error("division by zero returned nonzero words");

  // A valid result held by the output side stays valid next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> v_r[Last])
    else $error("stalled result item lost");

endmodule

// File: tb/natural32_alu_with_spill_shift_checker.sv
// ----------------------------------------------------------------------------
// natural32_alu_with_spill_shift_checker: result predictor and comparator
// Watches both channels of the ALU, computes the expected result of every
// accepted item and compares each accepted result item with the oldest one.
// ----------------------------------------------------------------------------
module natural32_alu_with_spill_shift_checker import nsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [5:0]  in_shift_count,
  input  logic [31:0] in_spill_in,
  input  logic [31:0] in_fill_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_result,
  input  logic [31:0] out_high_word,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] high_word;
    logic [2:0]  status;
  } alu_out_t;

  alu_out_t expected_q[$];

  // Logical shift of a word with fill entering and spill chaining.
  function automatic alu_out_t spill_shift(bit left, logic [5:0] n, logic [31:0] v,
                                           logic [31:0] spill, logic [31:0] fill);
    alu_out_t o;
    o.result = v;
    o.high_word = spill;
    o.status = (n > 6'd31) ? ST_SHIFT_FAR : ST_OK;
    if (n != 0 && n <= 6'd31) begin
      if (left) begin
        o.result = (v << n) | (fill >> (32 - n));
        o.high_word = (spill << n) | (v >> (32 - n));
      end else begin
        o.result = (v >> n) | (fill << (32 - n));
        o.high_word = (spill >> n) | (v << (32 - n));
      end
    end
    return o;
  endfunction

  function automatic alu_out_t alu_predict(logic [3:0] mode, logic [31:0] a,
                                           logic [31:0] b, logic [5:0] n,
                                           logic [31:0] spill, logic [31:0] fill);
    alu_out_t o;
    logic [32:0] sum;
    logic [63:0] prod;
    o = '0;
    case (mode)
      MODE_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        o.result = sum[31:0];
        o.status = sum[32] ? ST_CARRY : ST_OK;
      end
      MODE_SUB: begin
        o.result = a - b;
        o.status = (b > a) ? ST_BORROW : ST_OK;
      end
      MODE_MUL: begin
        prod = {32'd0, a} * {32'd0, b};
        o.result = prod[31:0];
        o.high_word = prod[63:32];
        o.status = (prod[63:32] == 0) ? ST_ONE_WORD : ST_TWO_WORD;
      end
      MODE_DIV: begin
        if (b == 0) o.status = ST_DIV_ZERO;
        else begin
          o.result = a / b;
          o.high_word = a % b;
        end
      end
      MODE_MOD: begin
        if (b == 0) o.status = ST_MOD_ZERO;
        else o.result = a % b;
      end
      MODE_AND: o.result = a & b;
      MODE_OR:  o.result = a | b;
      MODE_NOT: o.result = ~a;
      MODE_NEG: o.result = ~a + 32'd1;
      MODE_CMP: o.result = (a < b) ? 32'(CMP_LT) : ((a == b) ? 32'(CMP_EQ) : 32'(CMP_GT));
      MODE_INC: begin
        o.result = a + 32'd1;
        o.status = (a == 32'hFFFF_FFFF) ? ST_CARRY : ST_OK;
      end
      MODE_SHL: o = spill_shift(1'b1, n, a, spill, fill);
      MODE_SHR: o = spill_shift(1'b0, n, a, spill, fill);
      MODE_ASR: o = spill_shift(1'b0, n, a, spill, {32{a[31]}});
      default: o = '0;
    endcase
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alu_out_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(alu_predict(in_mode, in_operand_a, in_operand_b,
                                         in_shift_count, in_spill_in, in_fill_in));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item result=%h high_word=%h status=%0d",
                   $time, out_result, out_high_word, out_status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (want.result !== out_result) begin
            $display("%0t: result expected %h actual %h", $time, want.result, out_result);
            errs++;
          end
          if (want.high_word !== out_high_word) begin
            $display("%0t: high_word expected %h actual %h", $time, want.high_word,
                     out_high_word);
            errs++;
          end
          if (want.status !== out_status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: tb/natural32_alu_with_spill_shift_tb.sv
// ----------------------------------------------------------------------------
// natural32_alu_with_spill_shift_tb: top of the ALU testbench
// Drives directed and random items with random idling on both sides, holds
// the output off once long enough to fill the pipeline, and gives the verdict
// from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module natural32_alu_with_spill_shift_tb import nsa_pkg::*;;

  localparam int RandomItems = 1100;
  // The pipeline is 34 stages deep; allow a generous margin.
  localparam int DrainCycles = 100;
  localparam int IdleLimit   = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_mode;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [5:0]  in_shift_count;
  logic [31:0] in_spill_in;
  logic [31:0] in_fill_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result;
  logic [31:0] out_high_word;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending;
  bit          quiet_phase;
  bit          hold_req;
  int          idle_cycles;

  natural32_alu_with_spill_shift dut (.*);

  natural32_alu_with_spill_shift_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("natural32_alu_with_spill_shift_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold when asked,
  // and no stalling at all during the quiet phase near the end.
  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        // Long hold-off so that the pipeline fills and stalls its input.
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(3) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Presents one item and holds it until accepted; may idle before it.
  task automatic send_item(logic [3:0] mode, logic [31:0] a, logic [31:0] b,
                           logic [5:0] n, logic [31:0] spill, logic [31:0] fill);
    int gap;
    if (!quiet_phase && $urandom_range(4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_operand_a   <= a;
    in_operand_b   <= b;
    in_shift_count <= n;
    in_spill_in    <= spill;
    in_fill_in     <= fill;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Operand values lean toward edges so carries, borrows and zero divisors occur.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(15);
      4: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [3:0] m;
    logic [5:0] n;
    logic [31:0] a;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_shift_count = '0;
    in_spill_in = '0;
    in_fill_in = '0;
    quiet_phase = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: each mode, carry and borrow edges, zero divisors,
    // shift counts of zero, 31 and too far, the arithmetic fill of a negative
    // word, and the two unused mode codes.
    send_item(MODE_ADD, 32'hFFFF_FFFF, 32'd1, 6'd0, 32'd0, 32'd0);
    send_item(MODE_ADD, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_SUB, 32'd0, 32'd1, 6'd0, 32'd0, 32'd0);
    send_item(MODE_SUB, 32'd5, 32'd5, 6'd0, 32'd0, 32'd0);
    send_item(MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 32'd0, 32'd0);
    send_item(MODE_MUL, 32'd3, 32'd7, 6'd0, 32'd0, 32'd0);
    send_item(MODE_DIV, 32'hFFFF_FFFF, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_DIV, 32'hFFFF_FFFF, 32'd10, 6'd0, 32'd0, 32'd0);
    send_item(MODE_MOD, 32'd12345, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_MOD, 32'd12345, 32'd100, 6'd0, 32'd0, 32'd0);
    send_item(MODE_AND, 32'hF0F0_F0F0, 32'hFF00_FF00, 6'd0, 32'd0, 32'd0);
    send_item(MODE_OR, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 6'd0, 32'd0, 32'd0);
    send_item(MODE_NOT, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_NEG, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_CMP, 32'd1, 32'd2, 6'd0, 32'd0, 32'd0);
    send_item(MODE_CMP, 32'd2, 32'd2, 6'd0, 32'd0, 32'd0);
    send_item(MODE_CMP, 32'hFFFF_FFFF, 32'd2, 6'd0, 32'd0, 32'd0);
    send_item(MODE_INC, 32'hFFFF_FFFF, 32'd0, 6'd0, 32'd0, 32'd0);
    send_item(MODE_SHL, 32'h8000_0001, 32'd0, 6'd0, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(MODE_SHL, 32'h8000_0001, 32'd0, 6'd31, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(MODE_SHR, 32'h8000_0001, 32'd0, 6'd63, 32'h1234_5678, 32'hFFFF_FFFF);
    send_item(MODE_SHR, 32'h8000_0001, 32'd0, 6'd1, 32'hAAAA_AAAA, 32'h0000_0001);
    send_item(MODE_ASR, 32'h8000_0000, 32'd0, 6'd4, 32'hFFFF_FFFF, 32'd0);
    send_item(4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(4'd15, 32'd1, 32'd1, 6'd1, 32'd1, 32'd1);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == RandomItems - 150) quiet_phase = 1'b1;
      m = ($urandom_range(19) == 0) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(13));
      n = ($urandom_range(5) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom_range(31));
      a = pick_word();
      send_item(m, a, pick_word(), n, $urandom, $urandom);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("natural32_alu_with_spill_shift_tb: PASS");
    else
      $display("natural32_alu_with_spill_shift_tb: FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/nsa_pkg.sv
rtl/nsa_front.sv
rtl/natural32_alu_with_spill_shift.sv
tb/natural32_alu_with_spill_shift_checker.sv
tb/natural32_alu_with_spill_shift_tb.sv
